// ===== rtl/spp_pkg.sv =====
// Shared types and constants of the subscribe packet parser.
package spp_pkg;

   // Parser phases, one-hot
   typedef enum logic [7:0] {
      PH_TYPE  = 8'b0000_0001,
      PH_LEN   = 8'b0000_0010,
      PH_ID_HI = 8'b0000_0100,
      PH_ID_LO = 8'b0000_1000,
      PH_SL_HI = 8'b0001_0000,
      PH_SL_LO = 8'b0010_0000,
      PH_TOPIC = 8'b0100_0000,
      PH_QOS   = 8'b1000_0000
   } phase_type;

   // Final status codes of a packet
   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_TYPE         = 3'd1,
      ST_LEN_CODE     = 3'd2,
      ST_LEN_MISMATCH = 3'd3,
      ST_OVERRUN      = 3'd4,
      ST_QOS          = 3'd5
   } status_type;

   // Result kinds
   localparam logic KIND_FILTER = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Highest legal QoS level
   localparam logic [7:0] QOS_MAX = 8'd2;

   // Reset value of the expected header byte
   localparam logic [7:0] TYPE_BYTE_RESET = 8'h82;

   // Result queue geometry
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = 2;
   localparam int CNT_W      = 3;

   // Result output data width, padded to whole bytes
   localparam int RSP_DATA_W = 72;

   // One result
   typedef struct packed {
      logic        kind;
      status_type  status;
      logic [15:0] packet_ident;
      logic [28:0] topic_offset;
      logic [15:0] topic_length;
      logic [1:0]  qos_level;
      logic        last;
   } result_type;

   // Results caused by one request byte, first one first
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_out_type;

endpackage

// ===== rtl/spp_parser.sv =====
// Byte parser: packet state and the per-byte decode that yields up to two results.
module spp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_valid,
   input  logic [7:0]            step_byte,
   input  logic                  step_eom,
   input  logic [7:0]            expected_type,
   output spp_pkg::step_out_type step_out
);

   spp_pkg::phase_type  phase_ff, phase_in;
   logic                drop_ff, drop_in;
   logic [27:0]         rem_ff, rem_in;
   logic [1:0]          lcc_ff, lcc_in;
   logic [28:0]         pos_ff, pos_in;
   logic [15:0]         ident_ff, ident_in;
   logic [15:0]         slen_ff, slen_in;
   logic [15:0]         sleft_ff, sleft_in;
   logic [28:0]         tstart_ff, tstart_in;

   spp_pkg::status_type err;
   logic                filter_hit;
   logic                status_hit;
   logic [27:0]         rem_dec;
   logic [27:0]         len_acc;
   logic [15:0]         slen_full;
   spp_pkg::result_type filter_res;
   spp_pkg::result_type status_res;

   // Body bytes still allowed after this one, and the completed topic length
   assign rem_dec   = rem_ff - 28'd1;
   assign slen_full = {slen_ff[15:8], step_byte};

   // Merge the next base-128 length digit
   always_comb begin
      case (lcc_ff)
         2'd0:    len_acc = rem_ff | {21'b0, step_byte[6:0]};
         2'd1:    len_acc = rem_ff | {14'b0, step_byte[6:0], 7'b0};
         2'd2:    len_acc = rem_ff | {7'b0, step_byte[6:0], 14'b0};
         default: len_acc = rem_ff | {step_byte[6:0], 21'b0};
      endcase
   end

   // Decode one request byte
   always_comb begin
      phase_in   = phase_ff;
      drop_in    = drop_ff;
      rem_in     = rem_ff;
      lcc_in     = lcc_ff;
      pos_in     = pos_ff;
      ident_in   = ident_ff;
      slen_in    = slen_ff;
      sleft_in   = sleft_ff;
      tstart_in  = tstart_ff;
      err        = spp_pkg::ST_OK;
      filter_hit = 1'b0;
      status_hit = 1'b0;

      if (step_valid) begin
         if (drop_ff) begin
            // drop bytes until the end mark
            if (step_eom) begin
               drop_in  = 1'b0;
               phase_in = spp_pkg::PH_TYPE;
            end
         end else begin
            pos_in = pos_ff + 29'd1;
            case (phase_ff)
               spp_pkg::PH_TYPE: begin
                  // start a new packet
                  rem_in    = '0;
                  lcc_in    = '0;
                  pos_in    = 29'd1;
                  ident_in  = '0;
                  slen_in   = '0;
                  sleft_in  = '0;
                  tstart_in = '0;
                  if (step_byte != expected_type) begin
                     err = spp_pkg::ST_TYPE;
                  end else if (step_eom) begin
                     err = spp_pkg::ST_LEN_CODE;
                  end else begin
                     phase_in = spp_pkg::PH_LEN;
                  end
               end
               spp_pkg::PH_LEN: begin
                  rem_in = len_acc;
                  lcc_in = lcc_ff + 2'd1;
                  if (step_byte[7]) begin
                     // a fifth digit is never allowed
                     if (lcc_ff == 2'd3 || step_eom) begin
                        err = spp_pkg::ST_LEN_CODE;
                     end
                  end else if (len_acc < 28'd2) begin
                     err = spp_pkg::ST_LEN_MISMATCH;
                  end else begin
                     phase_in = spp_pkg::PH_ID_HI;
                  end
               end
               default: begin
                  // body byte: rem_ff counts body bytes not yet seen
                  if (rem_ff == 28'd0) begin
                     err = spp_pkg::ST_LEN_MISMATCH;
                  end else begin
                     rem_in = rem_dec;
                     case (phase_ff)
                        spp_pkg::PH_ID_HI: begin
                           ident_in = {step_byte, 8'h00};
                           phase_in = spp_pkg::PH_ID_LO;
                        end
                        spp_pkg::PH_ID_LO: begin
                           ident_in = {ident_ff[15:8], step_byte};
                           phase_in = spp_pkg::PH_SL_HI;
                        end
                        spp_pkg::PH_SL_HI: begin
                           if (rem_dec == 28'd0) begin
                              err = spp_pkg::ST_OVERRUN;
                           end else begin
                              slen_in  = {step_byte, 8'h00};
                              phase_in = spp_pkg::PH_SL_LO;
                           end
                        end
                        spp_pkg::PH_SL_LO: begin
                           slen_in = slen_full;
                           // topic plus QoS byte must fit in what is left
                           if (rem_dec <= {12'b0, slen_full}) begin
                              err = spp_pkg::ST_OVERRUN;
                           end else begin
                              tstart_in = pos_in;
                              sleft_in  = slen_full;
                              phase_in  = (slen_full != 16'd0) ? spp_pkg::PH_TOPIC
                                                               : spp_pkg::PH_QOS;
                           end
                        end
                        spp_pkg::PH_TOPIC: begin
                           sleft_in = sleft_ff - 16'd1;
                           if (sleft_ff == 16'd1) begin
                              phase_in = spp_pkg::PH_QOS;
                           end
                        end
                        spp_pkg::PH_QOS: begin
                           if (step_byte > spp_pkg::QOS_MAX) begin
                              err = spp_pkg::ST_QOS;
                           end else begin
                              filter_hit = 1'b1;
                              phase_in   = spp_pkg::PH_SL_HI;
                           end
                        end
                        default: begin
                           phase_in = spp_pkg::PH_TYPE;
                        end
                     endcase
                  end
               end
            endcase

            // end mark must fall on a filter boundary at the exact length
            if (err == spp_pkg::ST_OK && step_eom &&
                (rem_in != 28'd0 || phase_in != spp_pkg::PH_SL_HI)) begin
               err = spp_pkg::ST_LEN_MISMATCH;
            end

            // close the packet on error or end mark
            if (err != spp_pkg::ST_OK || step_eom) begin
               status_hit = 1'b1;
               if (step_eom) begin
                  phase_in = spp_pkg::PH_TYPE;
               end else begin
                  drop_in = 1'b1;
               end
            end
         end
      end
   end

   // Build the results
   always_comb begin
      filter_res.kind         = spp_pkg::KIND_FILTER;
      filter_res.status       = spp_pkg::ST_OK;
      filter_res.packet_ident = ident_in;
      filter_res.topic_offset = tstart_ff;
      filter_res.topic_length = slen_ff;
      filter_res.qos_level    = step_byte[1:0];
      filter_res.last         = !status_hit;

      status_res.kind         = spp_pkg::KIND_STATUS;
      status_res.status       = err;
      status_res.packet_ident = ident_in;
      status_res.topic_offset = '0;
      status_res.topic_length = '0;
      status_res.qos_level    = '0;
      status_res.last         = 1'b1;

      step_out.count  = {1'b0, filter_hit} + {1'b0, status_hit};
      step_out.first  = filter_hit ? filter_res : status_res;
      step_out.second = status_res;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= spp_pkg::PH_TYPE;
         drop_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         drop_ff  <= drop_in;
      end
   end

   // Packet fields
   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      lcc_ff    <= lcc_in;
      pos_ff    <= pos_in;
      ident_ff  <= ident_in;
      slen_ff   <= slen_in;
      sleft_ff  <= sleft_in;
      tstart_ff <= tstart_in;
   end

   // No results while dropping
   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      (drop_ff && step_valid) |-> (step_out.count == 2'd0))
      else $error("result produced while dropping");

   // Two results are a filter followed by a status
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (step_out.count == 2'd2) |->
      (step_out.first.kind == spp_pkg::KIND_FILTER &&
       step_out.second.kind == spp_pkg::KIND_STATUS))
      else $error("bad result pair");

   // Bad QoS inside a packet starts dropping
   a_qos_drop: assert property (@(posedge clock) disable iff (reset)
      (step_valid && !drop_ff && phase_ff == spp_pkg::PH_QOS && rem_ff != 28'd0 &&
       step_byte > spp_pkg::QOS_MAX && !step_eom) |=> drop_ff)
      else $error("QoS error did not start dropping");

endmodule

// ===== rtl/spp_result_fifo.sv =====
// Four-entry result queue that takes up to two results a cycle and gives one.
module spp_result_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  spp_pkg::step_out_type push,
   output logic                  in_room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output spp_pkg::result_type   out_item
);

   spp_pkg::result_type            mem_ff [spp_pkg::FIFO_DEPTH];
   logic [spp_pkg::PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [spp_pkg::PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [spp_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [spp_pkg::PTR_W-1:0]      wr_ptr_next;
   logic                           pop;

   // Room for a worst-case pair of results
   assign in_room   = count_ff <= spp_pkg::CNT_W'(spp_pkg::FIFO_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_item  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   assign wr_ptr_next = wr_ptr_ff + spp_pkg::PTR_W'(1);

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + spp_pkg::PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + spp_pkg::PTR_W'(pop);
      count_in  = count_ff + spp_pkg::CNT_W'(push.count) - spp_pkg::CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the results in order
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spp_pkg::CNT_W'(spp_pkg::FIFO_DEPTH))
      else $error("result queue count out of range");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> in_room)
      else $error("push without room");

   a_empty_push: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 && push.count != 2'd0) |=> out_valid)
      else $error("pushed result not presented");

endmodule

// ===== rtl/subscribe_packet_parser_unit.sv =====
// Top level of the subscribe packet parser: ports, type register, parser and result queue.
// Results of an accepted request byte are registered in the queue and offered on rsp.
// Throughput: one request byte per cycle; a byte that yields a filter and a status
// result needs two result beats, so req_tready drops while the result queue holds
// more than two entries.
// Reset: synchronous; parser waits for a type byte, queue empties, type register = 0x82.
module subscribe_packet_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [spp_pkg::RSP_DATA_W-1:0] rsp_tdata,
                        // [2:0] status, [18:3] packet_ident, [47:19] topic_offset,
                        // [63:48] topic_length, [65:64] qos_level, [71:66] zero
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic [7:0]            expected_type_ff, expected_type_in;
   logic                  step_valid;
   spp_pkg::step_out_type step_out;
   spp_pkg::result_type   out_item;

   // Type register write
   assign csr_ready        = 1'b1;
   assign expected_type_in = (csr_valid && csr_ready) ? csr_data : expected_type_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_type_ff <= spp_pkg::TYPE_BYTE_RESET;
      end else begin
         expected_type_ff <= expected_type_in;
      end
   end

   assign step_valid = req_tvalid && req_tready;

   spp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step_valid    (step_valid),
      .step_byte     (req_tdata),
      .step_eom      (req_tlast),
      .expected_type (expected_type_ff),
      .step_out      (step_out)
   );

   spp_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (step_out),
      .in_room   (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   // Pack the result
   assign rsp_tdata = {6'b0, out_item.qos_level, out_item.topic_length,
                       out_item.topic_offset, out_item.packet_ident, out_item.status};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the subscribe packet parser: directed packets, then random packets.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PHASES   = 5;
   localparam int ITEMS_PER_PHASE = 325;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int REPORT_LIMIT    = 10;
   localparam int N_DIRECTED      = 30;

   // One request byte, with a typed status result where it is obvious
   typedef struct packed {
      logic [7:0]          data;
      logic                eom;
      logic                typed;
      spp_pkg::status_type st;
      logic [15:0]         ident;
   } stim_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [spp_pkg::RSP_DATA_W-1:0] rsp_tdata;
                  // [2:0] status, [18:3] packet_ident, [47:19] topic_offset,
                  // [63:48] topic_length, [65:64] qos_level, [71:66] zero
   logic        rsp_tuser;           // [0] kind
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = 8'h00;

   subscribe_packet_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Parser shadow state
   logic [7:0]          type_byte_cfg = spp_pkg::TYPE_BYTE_RESET;
   spp_pkg::phase_type  prs_phase = spp_pkg::PH_TYPE;
   logic [27:0]         rem_total;
   logic [2:0]          code_count;
   logic [27:0]         body_seen;
   logic [28:0]         byte_pos;
   logic [15:0]         ident;
   logic [15:0]         str_len;
   logic [15:0]         str_left;
   logic [28:0]         topic_start;
   logic                dropping;

   spp_pkg::result_type step_results[$];
   spp_pkg::result_type awaited_results[$];
   logic [7:0]          pkt_bytes[$];
   int                  mismatch_count = 0;
   int                  accepted_bytes = 0;
   int                  quiet_cycles = 0;
   bit                  source_steady = 1'b0;
   bit                  sink_steady = 1'b0;
   bit                  hold_off_request = 1'b0;

   // Directed packets: type errors, long length code, short length, bad QoS,
   // filter overrun, and an empty topic ending a good packet
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{8'h00, 1'b1, 1'b1, spp_pkg::ST_TYPE,         16'h0000},
      '{8'hFF, 1'b0, 1'b1, spp_pkg::ST_TYPE,         16'h0000},
      '{8'h82, 1'b1, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'h82, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'hFF, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'hFF, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'hFF, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'hFF, 1'b1, 1'b1, spp_pkg::ST_LEN_CODE,     16'h0000},
      '{8'h82, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'h01, 1'b1, 1'b1, spp_pkg::ST_LEN_MISMATCH, 16'h0000},
      '{8'h82, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'h06, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'hAB, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'hCD, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'h00, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'h01, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'hFF, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'h03, 1'b1, 1'b1, spp_pkg::ST_QOS,          16'hABCD},
      '{8'h82, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'h03, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'h00, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'h00, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'h00, 1'b1, 1'b1, spp_pkg::ST_OVERRUN,      16'h0000},
      '{8'h82, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'h05, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'h12, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'h34, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'h00, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'h00, 1'b0, 1'b0, spp_pkg::ST_OK,           16'h0000},
      '{8'h02, 1'b1, 1'b0, spp_pkg::ST_OK,           16'h0000}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic spp_pkg::result_type make_result(logic kind, spp_pkg::status_type st,
                                                       logic [15:0] id, logic [28:0] off,
                                                       logic [15:0] len, logic [1:0] qos,
                                                       logic fin);
      spp_pkg::result_type r;
      r.kind         = kind;
      r.status       = st;
      r.packet_ident = id;
      r.topic_offset = off;
      r.topic_length = len;
      r.qos_level    = qos;
      r.last         = fin;
      return r;
   endfunction

   // Return the parser to the start of a packet
   function automatic void clear_parser();
      prs_phase   = spp_pkg::PH_TYPE;
      rem_total   = '0;
      code_count  = '0;
      body_seen   = '0;
      byte_pos    = '0;
      ident       = '0;
      str_len     = '0;
      str_left    = '0;
      topic_start = '0;
      dropping    = 1'b0;
   endfunction

   initial clear_parser();

   // Advance the shadow parser by one byte and collect the results it yields
   task automatic predict_byte(input logic [7:0] b, input logic eom);
      spp_pkg::status_type err;
      logic [31:0]         left;
      logic [1:0]          c;
      spp_pkg::result_type found;
      bit                  have_filter;
      bit                  need_status;
      step_results.delete();
      if (dropping) begin
         if (eom) clear_parser();
         return;
      end
      err = spp_pkg::ST_OK;
      have_filter = 1'b0;
      byte_pos = byte_pos + 29'd1;
      if (prs_phase == spp_pkg::PH_TYPE) begin
         clear_parser();
         byte_pos = 29'd1;
         if (b != type_byte_cfg) err = spp_pkg::ST_TYPE;
         else if (eom) err = spp_pkg::ST_LEN_CODE;
         else prs_phase = spp_pkg::PH_LEN;
      end else if (prs_phase == spp_pkg::PH_LEN) begin
         c = code_count[1:0];
         rem_total = rem_total | (28'(b[6:0]) << (7 * c));
         code_count = {1'b0, c} + 3'd1;
         if (b[7]) begin
            if (code_count >= 3'd4 || eom) err = spp_pkg::ST_LEN_CODE;
         end else if (rem_total < 28'd2) begin
            err = spp_pkg::ST_LEN_MISMATCH;
         end else begin
            prs_phase = spp_pkg::PH_ID_HI;
         end
      end else if (body_seen >= rem_total) begin
         err = spp_pkg::ST_LEN_MISMATCH;
      end else begin
         body_seen = body_seen + 28'd1;
         left = 32'(rem_total) - 32'(body_seen);
         case (prs_phase)
            spp_pkg::PH_ID_HI: begin
               ident = {b, 8'h00};
               prs_phase = spp_pkg::PH_ID_LO;
            end
            spp_pkg::PH_ID_LO: begin
               ident = ident | 16'(b);
               prs_phase = spp_pkg::PH_SL_HI;
            end
            spp_pkg::PH_SL_HI: begin
               if (left < 32'd1) begin
                  err = spp_pkg::ST_OVERRUN;
               end else begin
                  str_len = {b, 8'h00};
                  prs_phase = spp_pkg::PH_SL_LO;
               end
            end
            spp_pkg::PH_SL_LO: begin
               str_len = str_len | 16'(b);
               // topic plus QoS byte must fit in what is left of the body
               if (left < 32'(str_len) + 32'd1) begin
                  err = spp_pkg::ST_OVERRUN;
               end else begin
                  topic_start = byte_pos;
                  str_left = str_len;
                  prs_phase = (str_len != 16'd0) ? spp_pkg::PH_TOPIC : spp_pkg::PH_QOS;
               end
            end
            spp_pkg::PH_TOPIC: begin
               str_left = str_left - 16'd1;
               if (str_left == 16'd0) prs_phase = spp_pkg::PH_QOS;
            end
            default: begin
               if (b > spp_pkg::QOS_MAX) begin
                  err = spp_pkg::ST_QOS;
               end else begin
                  found = make_result(spp_pkg::KIND_FILTER, spp_pkg::ST_OK, ident,
                                      topic_start, str_len, b[1:0], 1'b0);
                  have_filter = 1'b1;
                  prs_phase = spp_pkg::PH_SL_HI;
               end
            end
         endcase
      end
      // end mark must fall exactly at the end of the body, between filters
      if (err == spp_pkg::ST_OK && eom &&
          (body_seen != rem_total || prs_phase != spp_pkg::PH_SL_HI))
         err = spp_pkg::ST_LEN_MISMATCH;
      need_status = (err != spp_pkg::ST_OK) || eom;
      if (have_filter) begin
         found.last = !need_status;
         step_results.push_back(found);
      end
      if (need_status) begin
         step_results.push_back(make_result(spp_pkg::KIND_STATUS, err, ident,
                                            '0, '0, '0, 1'b1));
         if (eom) clear_parser();
         else dropping = 1'b1;
      end
   endtask

   function automatic int idle_length(bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one request byte, wait for it to be taken, then log its expected results
   task automatic send_request(input stim_row_type row);
      int gap;
      gap = idle_length(source_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row.data;
      req_tlast  <= row.eom;
      do @(posedge clock); while (!req_tready);
      predict_byte(row.data, row.eom);
      accepted_bytes++;
      if (row.typed)
         awaited_results.push_back(make_result(spp_pkg::KIND_STATUS, row.st, row.ident,
                                               '0, '0, '0, 1'b1));
      else
         foreach (step_results[i]) awaited_results.push_back(step_results[i]);
   endtask

   // Stop sending and wait until every expected result is out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_type_reg(input logic [7:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      type_byte_cfg = value;
      csr_valid <= 1'b0;
   endtask

   // Build one packet: mostly well formed with random content, some flawed or noise
   task automatic build_packet(input logic [7:0] type_value);
      logic [7:0]  body[$];
      logic [27:0] rem;
      int n_filters, tlen, pad, flaw, cut, pick, i;
      pkt_bytes.delete();
      body.push_back(8'($urandom));
      body.push_back(8'($urandom));
      n_filters = $urandom_range(0, 3);
      for (i = 0; i < n_filters; i++) begin
         pick = $urandom_range(0, 99);
         tlen = (pick < 2) ? $urandom_range(256, 300) :
                (pick < 12) ? $urandom_range(7, 40) : $urandom_range(0, 6);
         body.push_back(8'(tlen >> 8));
         body.push_back(8'(tlen));
         repeat (tlen) body.push_back(8'($urandom));
         body.push_back(8'($urandom_range(0, 2)));
      end
      pkt_bytes.push_back(type_value);
      // base-128 remaining length, low group first
      rem = 28'(body.size());
      do begin
         pkt_bytes.push_back({rem > 28'd127, rem[6:0]});
         rem = rem >> 7;
      end while (rem != 28'd0);
      // sometimes stretch the code with redundant zero groups, up to four bytes
      if ($urandom_range(0, 99) < 15) begin
         pad = $urandom_range(1, 5 - pkt_bytes.size());
         repeat (pad) begin
            pkt_bytes[pkt_bytes.size() - 1] = pkt_bytes[pkt_bytes.size() - 1] | 8'h80;
            pkt_bytes.push_back(8'h00);
         end
      end
      foreach (body[j]) pkt_bytes.push_back(body[j]);
      flaw = $urandom_range(0, 99);
      if (flaw < 66) begin
         // keep it well formed
      end else if (flaw < 71) begin
         pkt_bytes[0] = pkt_bytes[0] ^ 8'($urandom_range(1, 255));
      end else if (flaw < 77) begin
         cut = $urandom_range(1, pkt_bytes.size() - 1);
         while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      end else if (flaw < 82) begin
         repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom));
      end else if (flaw < 87) begin
         pick = $urandom_range(1, pkt_bytes.size() - 1);
         pkt_bytes[pick] = 8'($urandom);
      end else if (flaw < 91) begin
         if (n_filters > 0) pkt_bytes[pkt_bytes.size() - 1] = 8'($urandom_range(3, 255));
      end else if (flaw < 94) begin
         // length code that never terminates
         pkt_bytes.delete();
         pkt_bytes.push_back(type_value);
         repeat (4) pkt_bytes.push_back(8'h80 | 8'($urandom));
         repeat ($urandom_range(0, 3)) pkt_bytes.push_back(8'($urandom));
      end else begin
         pkt_bytes.delete();
         if ($urandom_range(0, 1)) pkt_bytes.push_back(type_value);
         repeat ($urandom_range(1, 8)) pkt_bytes.push_back(8'($urandom));
      end
   endtask

   // Result sink: random stalls, plus one long hold-off on request
   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
         end
         if (stall_left == 0) stall_left = idle_length(sink_steady);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic void report_result_error(string what, spp_pkg::result_type want,
                                               spp_pkg::result_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%s: expected kind=%0d status=%0d ident=%h offset=%0d length=%0d qos=%0d",
                  what, want.kind, want.status, want.packet_ident, want.topic_offset,
                  want.topic_length, want.qos_level);
         $display("   expected last=%0d, got kind=%0d status=%0d ident=%h offset=%0d",
                  want.last, got.kind, got.status, got.packet_ident, got.topic_offset);
         $display("   got length=%0d qos=%0d last=%0d",
                  got.topic_length, got.qos_level, got.last);
      end
   endfunction

   // Compare each result taken from the block with the oldest expectation
   always @(posedge clock) begin : result_check
      spp_pkg::result_type got;
      spp_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = make_result(rsp_tuser, spp_pkg::status_type'(rsp_tdata[2:0]),
                           rsp_tdata[18:3], rsp_tdata[47:19], rsp_tdata[63:48],
                           rsp_tdata[65:64], rsp_tlast);
         if (awaited_results.size() == 0) begin
            report_result_error("unexpected result", '0, got);
         end else begin
            want = awaited_results.pop_front();
            if (got !== want) report_result_error("result mismatch", want, got);
         end
      end
   end

   // Watchdog: count cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [7:0]   phase_type_bytes [RANDOM_PHASES];
      logic [7:0]   type_value;
      stim_row_type row;
      int           p;
      int           phase_target;
      phase_type_bytes = '{spp_pkg::TYPE_BYTE_RESET, 8'h00, 8'hFF, 8'h00,
                           spp_pkg::TYPE_BYTE_RESET};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed packets under the reset type byte
      for (int i = 0; i < N_DIRECTED; i++) send_request(directed_rows[i]);

      // Random packets, one type byte setting per phase
      for (p = 0; p < RANDOM_PHASES; p++) begin
         type_value = (p == 3) ? 8'($urandom_range(0, 255)) : phase_type_bytes[p];
         write_type_reg(type_value);
         source_steady = (p == 2);
         sink_steady   = (p == 3);
         if (p == 1) hold_off_request = 1'b1;
         phase_target = accepted_bytes + ITEMS_PER_PHASE;
         while (accepted_bytes < phase_target) begin
            build_packet(type_value);
            foreach (pkt_bytes[k]) begin
               row.data  = pkt_bytes[k];
               row.eom   = (k == pkt_bytes.size() - 1);
               row.typed = 1'b0;
               row.st    = spp_pkg::ST_OK;
               row.ident = 16'h0000;
               send_request(row);
            end
         end
      end

      drain_results();
      if (mismatch_count == 0 && awaited_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
